### rtl/door_triggered_serial_pattern_injector_defines.svh
// ----------------------------------------------------------------------------
// door triggered serial pattern injector assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef DOOR_TRIGGERED_SERIAL_PATTERN_INJECTOR_DEFINES_SVH
`define DOOR_TRIGGERED_SERIAL_PATTERN_INJECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define DTSPI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked outside reset
`define DTSPI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DTSPI_ASSERT_IMP(label, ante, cons)
`define DTSPI_ASSERT_NXT(label, ante, cons)
`endif

`endif

### rtl/dtspi_pkg.sv
// ----------------------------------------------------------------------------
// dtspi_pkg
// shared types, register codes and character tables of the injector
// ----------------------------------------------------------------------------
`default_nettype none

package dtspi_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_TICKS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKE_TICKS     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_GATE_TICKS     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS   = 3'd7;

    // region mode codes
    localparam logic [2:0] REGION_ROTATE = 3'd0;
    localparam logic [2:0] REGION_A      = 3'd1;
    localparam logic [2:0] REGION_E      = 3'd2;
    localparam logic [2:0] REGION_I      = 3'd3;
    localparam logic [2:0] REGION_W      = 3'd4;

    // register reset values
    localparam logic [2:0]  RST_REGION_MODE    = REGION_ROTATE;
    localparam logic [7:0]  RST_REPEAT_COUNT   = 8'd30;
    localparam logic [7:0]  RST_BIT_TICKS      = 8'd4;
    localparam logic [7:0]  RST_GAP_TICKS      = 8'd72;
    localparam logic [15:0] RST_DEBOUNCE_TICKS = 16'd50;
    localparam logic [15:0] RST_WAKE_TICKS     = 16'd50;
    localparam logic [15:0] RST_GATE_TICKS     = 16'd850;
    localparam logic [15:0] RST_SETTLE_TICKS   = 16'd314;

    // frame position of the stop period
    localparam logic [3:0] BIT_STOP = 4'd9;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WAKE   = 3'd1,
        PH_GATE   = 3'd2,
        PH_SETTLE = 3'd3,
        PH_BITS   = 3'd4,
        PH_GAP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0]  region_mode;
        logic [7:0]  repeat_count;
        logic [7:0]  bit_ticks;
        logic [7:0]  gap_ticks;
        logic [15:0] debounce_ticks;
        logic [15:0] wake_ticks;
        logic [15:0] gate_ticks;
        logic [15:0] settle_ticks;
    } dtspi_cfg_t;

    typedef struct packed {
        logic data_release;
        logic gate_release;
        logic busy;
    } dtspi_res_t;

    function automatic logic [7:0] head_char(input logic [1:0] idx);
        case (idx)
            2'd0:    return 8'b0101_0011;
            2'd1:    return 8'b0100_0011;
            default: return 8'b0100_0101;
        endcase
    endfunction

    function automatic logic [7:0] tail_char(input logic [1:0] idx);
        case (idx)
            2'd0:    return 8'b0100_0001;
            2'd1:    return 8'b0100_0101;
            2'd2:    return 8'b0100_1001;
            default: return 8'b0101_0111;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/dtspi_cfg.sv
// ----------------------------------------------------------------------------
// dtspi_cfg
// configuration register file written through the write channel
// ----------------------------------------------------------------------------
`default_nettype none

module dtspi_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dtspi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dtspi_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dtspi_pkg::dtspi_cfg_t                  cfg
);
    import dtspi_pkg::*;

    dtspi_cfg_t cfg_reg;
    dtspi_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_REGION_MODE:    cfg_next.region_mode    = cfg_data[2:0];
                REG_REPEAT_COUNT:   cfg_next.repeat_count   = cfg_data[7:0];
                REG_BIT_TICKS:      cfg_next.bit_ticks      = cfg_data[7:0];
                REG_GAP_TICKS:      cfg_next.gap_ticks      = cfg_data[7:0];
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = cfg_data;
                REG_WAKE_TICKS:     cfg_next.wake_ticks     = cfg_data;
                REG_GATE_TICKS:     cfg_next.gate_ticks     = cfg_data;
                REG_SETTLE_TICKS:   cfg_next.settle_ticks   = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_mode    <= RST_REGION_MODE;
            cfg_reg.repeat_count   <= RST_REPEAT_COUNT;
            cfg_reg.bit_ticks      <= RST_BIT_TICKS;
            cfg_reg.gap_ticks      <= RST_GAP_TICKS;
            cfg_reg.debounce_ticks <= RST_DEBOUNCE_TICKS;
            cfg_reg.wake_ticks     <= RST_WAKE_TICKS;
            cfg_reg.gate_ticks     <= RST_GATE_TICKS;
            cfg_reg.settle_ticks   <= RST_SETTLE_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dtspi_seq.sv
// ----------------------------------------------------------------------------
// dtspi_seq
// tick sequencer: debounce, arming, segment timing and character framing
// ----------------------------------------------------------------------------
`default_nettype none

module dtspi_seq #(
    parameter int COUNTER_BITS = dtspi_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tick_en,
    input  wire logic                  door_level,
    input  dtspi_pkg::dtspi_cfg_t      cfg,
    output dtspi_pkg::dtspi_res_t      res
);
    import dtspi_pkg::*;

    localparam int CW = COUNTER_BITS;
    // upper bound on the chain of segments that can close within one tick
    localparam int SKIP_STEPS = 4;
    localparam logic [CW-1:0] CNT_MAX = '1;

    typedef struct packed {
        phase_t        phase;
        logic [CW-1:0] wait_cnt;
        logic [3:0]    bit_idx;
        logic [1:0]    char_idx;
        logic [1:0]    str_idx;
        logic [7:0]    grp_cnt;
        logic          armed;
        logic [CW-1:0] deb_cnt;
        logic          debouncing;
        logic          door_prev;
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;
    dtspi_res_t res_comb;

    function automatic logic [CW-1:0] clamp_cnt(input logic [15:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(CNT_MAX))
            return CNT_MAX;
        return w[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] seg_len(input seq_state_t s, input dtspi_cfg_t c);
        logic [7:0] b;
        b = (c.bit_ticks == 8'd0) ? 8'd1 : c.bit_ticks;
        case (s.phase)
            PH_WAKE:   return clamp_cnt(c.wake_ticks);
            PH_GATE:   return clamp_cnt(c.gate_ticks);
            PH_SETTLE: return clamp_cnt(c.settle_ticks);
            PH_BITS:   return (s.bit_idx >= BIT_STOP) ? CW'({b, 1'b0}) : CW'(b);
            PH_GAP:    return clamp_cnt(16'(c.gap_ticks));
            default:   return '0;
        endcase
    endfunction

    function automatic seq_state_t advance(input seq_state_t s, input dtspi_cfg_t c);
        seq_state_t t;
        t = s;
        case (s.phase)
            PH_WAKE:   t.phase = PH_GATE;
            PH_GATE:   t.phase = PH_SETTLE;
            PH_SETTLE:
            begin
                t.bit_idx  = '0;
                t.char_idx = '0;
                t.str_idx  = '0;
                t.grp_cnt  = '0;
                if (c.repeat_count == 8'd0)
                begin
                    t.phase = PH_IDLE;
                    t.armed = 1'b0;
                end
                else
                begin
                    t.phase = PH_BITS;
                end
            end
            PH_BITS:
            begin
                if (s.bit_idx < BIT_STOP)
                begin
                    t.bit_idx = s.bit_idx + 4'd1;
                end
                else
                begin
                    t.bit_idx = '0;
                    if (s.char_idx != 2'd3)
                    begin
                        t.char_idx = s.char_idx + 2'd1;
                    end
                    else
                    begin
                        t.char_idx = '0;
                        t.phase    = PH_GAP;
                    end
                end
            end
            PH_GAP:
            begin
                t.phase = PH_BITS;
                if (s.str_idx == 2'd3)
                begin
                    t.str_idx = '0;
                    t.grp_cnt = s.grp_cnt + 8'd1;
                    if (t.grp_cnt >= c.repeat_count)
                    begin
                        t.phase = PH_IDLE;
                        t.armed = 1'b0;
                    end
                end
                else
                begin
                    t.str_idx = s.str_idx + 2'd1;
                end
            end
            default: t.phase = PH_IDLE;
        endcase
        t.wait_cnt = '0;
        return t;
    endfunction

    // next state
    always_comb
    begin
        seq_state_t s;
        s = state_reg;

        if (s.phase == PH_IDLE)
        begin
            if (!s.debouncing && s.door_prev && !door_level)
            begin
                s.debouncing = 1'b1;
                s.deb_cnt    = '0;
            end
            if (s.debouncing)
            begin
                if (s.deb_cnt >= clamp_cnt(cfg.debounce_ticks))
                begin
                    if (!door_level)
                        s.armed = 1'b1;
                    s.debouncing = 1'b0;
                end
                else
                begin
                    s.deb_cnt = s.deb_cnt + 1'b1;
                end
            end
        end
        s.door_prev = door_level;

        if (s.phase == PH_IDLE && s.armed)
        begin
            s.phase    = PH_WAKE;
            s.wait_cnt = '0;
        end

        // close finished segments and skip empty ones
        for (int i = 0; i < SKIP_STEPS; i++)
        begin
            if (s.phase != PH_IDLE && s.wait_cnt >= seg_len(s, cfg))
                s = advance(s, cfg);
        end

        state_next = s;
        if (s.phase != PH_IDLE && s.wait_cnt != CNT_MAX)
            state_next.wait_cnt = s.wait_cnt + 1'b1;
    end

    // line levels for this tick
    always_comb
    begin
        logic [7:0] ch;
        logic [2:0] bsel;
        if (state_next.char_idx != 2'd3)
            ch = head_char(state_next.char_idx);
        else if (cfg.region_mode >= REGION_A && cfg.region_mode <= REGION_W)
            ch = tail_char(2'(cfg.region_mode - REGION_A));
        else
            ch = tail_char(state_next.str_idx);
        bsel = 3'(state_next.bit_idx - 4'd1);

        res_comb.data_release = 1'b1;
        res_comb.gate_release = 1'b1;
        res_comb.busy         = (state_next.phase != PH_IDLE);
        case (state_next.phase)
            PH_GATE:
            begin
                res_comb.data_release = 1'b0;
            end
            PH_SETTLE, PH_GAP:
            begin
                res_comb.data_release = 1'b0;
                res_comb.gate_release = 1'b0;
            end
            PH_BITS:
            begin
                res_comb.gate_release = 1'b0;
                if (state_next.bit_idx == 4'd0)
                    res_comb.data_release = 1'b1;
                else if (state_next.bit_idx >= BIT_STOP)
                    res_comb.data_release = 1'b0;
                else
                    res_comb.data_release = ~ch[bsel];
            end
            default:
            begin
                res_comb.data_release = 1'b1;
                res_comb.gate_release = 1'b1;
            end
        endcase
    end

    assign res = res_comb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_IDLE;
            state_reg.wait_cnt   <= '0;
            state_reg.bit_idx    <= '0;
            state_reg.char_idx   <= '0;
            state_reg.str_idx    <= '0;
            state_reg.grp_cnt    <= '0;
            state_reg.armed      <= 1'b1;
            state_reg.deb_cnt    <= '0;
            state_reg.debouncing <= 1'b0;
            state_reg.door_prev  <= 1'b1;
        end
        else if (tick_en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/door_triggered_serial_pattern_injector.sv
// ----------------------------------------------------------------------------
// door_triggered_serial_pattern_injector
// door triggered timed serial pattern injector, one beat per tick
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid, in_stall, door_level): one beat per tick with
//   the sampled door pin. output channel (out_valid, out_stall,
//   data_release, gate_release, busy_res): one beat per input beat giving
//   the line levels for that tick.
//   configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data):
//   cfg_ready is always high; write only while no tick is in flight.
//   a result is registered and appears in the cycle after its tick is accepted.
//   throughput: one tick per cycle unless a held result stalls the input,
//   set by the single sequencer state register that every tick updates.
//   a stalled result holds in the output register; a new tick is taken in
//   the same cycle that the held result is taken, so in_stall is high only
//   while a result waits and out_stall is high.
//   reset: all registers but the result payload take their reset values, the
//   block comes up armed and starts a sequence on the first tick.
// ----------------------------------------------------------------------------
`default_nettype none

`include "door_triggered_serial_pattern_injector_defines.svh"

module door_triggered_serial_pattern_injector #(
    parameter int COUNTER_BITS = dtspi_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              door_level,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   data_release,
    output logic                                   gate_release,
    output logic                                   busy_res,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dtspi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dtspi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dtspi_pkg::*;

    dtspi_cfg_t cfg;
    dtspi_res_t res;
    dtspi_res_t res_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    dtspi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtspi_seq #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (in_accept),
        .door_level (door_level),
        .cfg        (cfg),
        .res        (res)
    );

    always_comb
    begin
        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload, loaded only with an accepted tick
    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign data_release = res_reg.data_release;
    assign gate_release = res_reg.gate_release;
    assign busy_res     = res_reg.busy;

    // every accepted tick leaves a result beat behind
    `DTSPI_ASSERT_NXT(a_tick_gives_beat, in_valid && !in_stall, out_valid)
    // idle block releases both lines
    `DTSPI_ASSERT_IMP(a_idle_released, out_valid && !busy_res, data_release && gate_release)
    // gate is only driven during a sequence
    `DTSPI_ASSERT_IMP(a_gate_only_busy, out_valid && !gate_release, busy_res)

endmodule

`default_nettype wire

### tb/door_triggered_serial_pattern_injector_tb.sv
// ----------------------------------------------------------------------------
// door_triggered_serial_pattern_injector_tb
// drives door ticks through the valid/stall channel and predicts the data,
// gate and busy line levels of every tick with a cycle-free model of the
// sequencer. a directed table covers reset, zero-length segments, no-group
// runs, debounce and out-of-range region codes, then random phases with
// small, minimal and maximal settings run door press patterns under random
// idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module door_triggered_serial_pattern_injector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dtspi_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // longest legal quiet run is the hold-off
    localparam int HOLD_CYCLES    = 100;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_TICKS    = 150;
    localparam int WAIT_TOP       = 65535;
    // unassigned region code, falls back to rotation
    localparam logic [2:0] REGION_UNUSED = 3'd7;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;
    typedef enum int {MIX_SMALL, ALL_MIN, ALL_MAX} setting_style_t;

    typedef struct packed {
        row_kind_t                kind;
        logic                     door;
        logic [CFG_INDEX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        logic                     pinned;
        dtspi_res_t               want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   door_level;
    logic                   out_valid;
    logic                   out_stall;
    logic                   data_release;
    logic                   gate_release;
    logic                   busy_res;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    door_triggered_serial_pattern_injector uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .door_level   (door_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_release (data_release),
        .gate_release (gate_release),
        .busy_res     (busy_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // model state
    dtspi_cfg_t  live_cfg;
    phase_t      seq_phase;
    int          wait_cnt;
    logic [3:0]  bit_pos;
    logic [1:0]  char_pos;
    logic [1:0]  string_pos;
    logic [7:0]  group_cnt;
    logic        armed;
    logic [15:0] debounce_cnt;
    logic        debouncing;
    logic        door_last;

    dtspi_res_t  line_levels_q [$];
    int          mismatch_count;
    int          quiet_cycles;
    logic        gaps_on;
    logic        hold_req;
    logic        pin_on;
    dtspi_res_t  pin_res;
    plan_row_t   plan [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_model();
        live_cfg.region_mode    = RST_REGION_MODE;
        live_cfg.repeat_count   = RST_REPEAT_COUNT;
        live_cfg.bit_ticks      = RST_BIT_TICKS;
        live_cfg.gap_ticks      = RST_GAP_TICKS;
        live_cfg.debounce_ticks = RST_DEBOUNCE_TICKS;
        live_cfg.wake_ticks     = RST_WAKE_TICKS;
        live_cfg.gate_ticks     = RST_GATE_TICKS;
        live_cfg.settle_ticks   = RST_SETTLE_TICKS;
        seq_phase    = PH_IDLE;
        wait_cnt     = 0;
        bit_pos      = '0;
        char_pos     = '0;
        string_pos   = '0;
        group_cnt    = '0;
        armed        = 1'b1;
        debounce_cnt = '0;
        debouncing   = 1'b0;
        door_last    = 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_REGION_MODE:    live_cfg.region_mode    = val[2:0];
            REG_REPEAT_COUNT:   live_cfg.repeat_count   = val[7:0];
            REG_BIT_TICKS:      live_cfg.bit_ticks      = val[7:0];
            REG_GAP_TICKS:      live_cfg.gap_ticks      = val[7:0];
            REG_DEBOUNCE_TICKS: live_cfg.debounce_ticks = val;
            REG_WAKE_TICKS:     live_cfg.wake_ticks     = val;
            REG_GATE_TICKS:     live_cfg.gate_ticks     = val;
            default:            live_cfg.settle_ticks   = val;
        endcase
    endfunction

    function automatic int segment_ticks();
        int unit_ticks;
        unit_ticks = (live_cfg.bit_ticks == 8'd0) ? 1 : int'(live_cfg.bit_ticks);
        case (seq_phase)
            PH_WAKE:   return int'(live_cfg.wake_ticks);
            PH_GATE:   return int'(live_cfg.gate_ticks);
            PH_SETTLE: return int'(live_cfg.settle_ticks);
            PH_BITS:   return (bit_pos >= BIT_STOP) ? 2 * unit_ticks : unit_ticks;
            PH_GAP:    return int'(live_cfg.gap_ticks);
            default:   return 0;
        endcase
    endfunction

    function automatic logic [7:0] frame_char();
        logic [1:0] sel;
        case (char_pos)
            2'd0:    return 8'h53;
            2'd1:    return 8'h43;
            2'd2:    return 8'h45;
            default: ;
        endcase
        if (live_cfg.region_mode >= REGION_A && live_cfg.region_mode <= REGION_W)
            sel = live_cfg.region_mode[1:0] - REGION_A[1:0];
        else
            sel = string_pos;
        case (sel)
            2'd0:    return 8'h41;
            2'd1:    return 8'h45;
            2'd2:    return 8'h49;
            default: return 8'h57;
        endcase
    endfunction

    function automatic void advance_segment();
        case (seq_phase)
            PH_WAKE:   seq_phase = PH_GATE;
            PH_GATE:   seq_phase = PH_SETTLE;
            PH_SETTLE:
            begin
                bit_pos    = '0;
                char_pos   = '0;
                string_pos = '0;
                group_cnt  = '0;
                if (live_cfg.repeat_count == 8'd0)
                begin
                    seq_phase = PH_IDLE;
                    armed     = 1'b0;
                end
                else
                    seq_phase = PH_BITS;
            end
            PH_BITS:
            begin
                if (bit_pos < BIT_STOP)
                    bit_pos = bit_pos + 4'd1;
                else
                begin
                    bit_pos = '0;
                    if (char_pos < 2'd3)
                        char_pos = char_pos + 2'd1;
                    else
                    begin
                        char_pos  = '0;
                        seq_phase = PH_GAP;
                    end
                end
            end
            PH_GAP:
            begin
                seq_phase = PH_BITS;
                if (string_pos == 2'd3)
                begin
                    string_pos = '0;
                    group_cnt  = group_cnt + 8'd1;
                    if (group_cnt >= live_cfg.repeat_count)
                    begin
                        seq_phase = PH_IDLE;
                        armed     = 1'b0;
                    end
                end
                else
                    string_pos = string_pos + 2'd1;
            end
            default:   seq_phase = PH_IDLE;
        endcase
        wait_cnt = 0;
    endfunction

    // line levels of one tick, updating the model state
    function automatic dtspi_res_t predict_lines(input logic door);
        dtspi_res_t lines;
        logic [7:0] ch;
        lines.data_release = 1'b1;
        lines.gate_release = 1'b1;
        if (seq_phase == PH_IDLE)
        begin
            if (!debouncing && door_last && !door)
            begin
                debouncing   = 1'b1;
                debounce_cnt = '0;
            end
            if (debouncing)
            begin
                // pin only looked at when the interval runs out
                if (debounce_cnt >= live_cfg.debounce_ticks)
                begin
                    if (!door)
                        armed = 1'b1;
                    debouncing = 1'b0;
                end
                else
                    debounce_cnt = debounce_cnt + 16'd1;
            end
        end
        door_last = door;
        if (seq_phase == PH_IDLE && armed)
        begin
            seq_phase = PH_WAKE;
            wait_cnt  = 0;
        end
        // finished and zero-length segments fall through in the same tick
        while (seq_phase != PH_IDLE && wait_cnt >= segment_ticks())
            advance_segment();
        case (seq_phase)
            PH_GATE:   lines.data_release = 1'b0;
            PH_SETTLE, PH_GAP:
            begin
                lines.data_release = 1'b0;
                lines.gate_release = 1'b0;
            end
            PH_BITS:
            begin
                lines.gate_release = 1'b0;
                ch = frame_char();
                if (bit_pos == 4'd0)
                    lines.data_release = 1'b1;
                else if (bit_pos >= BIT_STOP)
                    lines.data_release = 1'b0;
                else
                    lines.data_release = ~ch[3'(bit_pos - 4'd1)];
            end
            default: ;
        endcase
        if (seq_phase != PH_IDLE && wait_cnt < WAIT_TOP)
            wait_cnt = wait_cnt + 1;
        lines.busy = (seq_phase != PH_IDLE);
        return lines;
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin : check_lines
        dtspi_res_t got;
        dtspi_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.data_release = data_release;
                got.gate_release = gate_release;
                got.busy         = busy_res;
                if (line_levels_q.size() == 0)
                    note_failure($sformatf("unexpected beat data %b gate %b busy %b",
                                           got.data_release, got.gate_release, got.busy));
                else
                begin
                    want = line_levels_q.pop_front();
                    if (got.data_release !== want.data_release ||
                        got.gate_release !== want.gate_release ||
                        got.busy !== want.busy)
                        note_failure($sformatf(
                            "lines: expected data %b gate %b busy %b, got %b %b %b",
                            want.data_release, want.gate_release, want.busy,
                            got.data_release, got.gate_release, got.busy));
                end
            end
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                want = predict_lines(door_level);
                if (pin_on)
                    want = pin_res;
                line_levels_q.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall <= gaps_on && ($urandom_range(0, 99) < 30);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_tick(input logic door, input logic pinned, input dtspi_res_t res);
        while (gaps_on && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pin_on = pinned;
        pin_res = res;
        in_valid   <= 1'b1;
        door_level <= door;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // leaves cfg_valid high, the caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (line_levels_q.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_val(input int small_top, input int top);
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return 16'd0;
        if (roll == 1)
            return 16'(top);
        return 16'($urandom_range(0, small_top));
    endfunction

    function automatic dtspi_cfg_t pick_settings(input setting_style_t style);
        dtspi_cfg_t s;
        if (style == ALL_MIN)
            s = '0;
        else if (style == ALL_MAX)
            s = '1;
        else
        begin
            s.region_mode    = 3'($urandom_range(0, 7));
            s.repeat_count   = 8'(pick_val(2, 255));
            s.bit_ticks      = 8'(pick_val(2, 255));
            s.gap_ticks      = 8'(pick_val(4, 255));
            s.debounce_ticks = pick_val(6, 65535);
            s.wake_ticks     = pick_val(4, 65535);
            s.gate_ticks     = pick_val(4, 65535);
            s.settle_ticks   = pick_val(4, 65535);
        end
        return s;
    endfunction

    task automatic load_settings(input dtspi_cfg_t s);
        logic [15:0] junk;
        // unused high bits of the narrow registers get random filler
        junk = 16'($urandom);
        write_reg(REG_REGION_MODE, {junk[15:3], s.region_mode});
        write_reg(REG_REPEAT_COUNT, {junk[7:0], s.repeat_count});
        write_reg(REG_BIT_TICKS, {junk[15:8], s.bit_ticks});
        write_reg(REG_GAP_TICKS, {junk[11:4], s.gap_ticks});
        write_reg(REG_DEBOUNCE_TICKS, s.debounce_ticks);
        write_reg(REG_WAKE_TICKS, s.wake_ticks);
        write_reg(REG_GATE_TICKS, s.gate_ticks);
        write_reg(REG_SETTLE_TICKS, s.settle_ticks);
        cfg_valid <= 1'b0;
    endtask

    function automatic plan_row_t tick_row(input logic door, input logic pinned,
                                           input logic [2:0] lines);
        plan_row_t r;
        r = '0;
        r.kind   = ROW_TICK;
        r.door   = door;
        r.pinned = pinned;
        r.want   = dtspi_res_t'(lines);
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial
    begin
        setting_style_t style;
        dtspi_cfg_t     s;
        logic           cfg_open;
        logic           door_now;
        int             run_left;
        int             press_len;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        door_level     = 1'b1;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        gaps_on        = 1'b1;
        hold_req       = 1'b0;
        pin_on         = 1'b0;
        pin_res        = '0;
        mismatch_count = 0;
        cfg_open       = 1'b0;
        reset_model();

        // lines packed as {data, gate, busy}
        plan = '{
            tick_row(1'b1, 1'b1, 3'b111),   // armed out of reset, waking
            tick_row(1'b0, 1'b1, 3'b111),   // door ignored while busy
            tick_row(1'b1, 1'b1, 3'b111),
            reg_row(REG_REPEAT_COUNT, 16'd0),
            reg_row(REG_WAKE_TICKS, 16'd0),
            reg_row(REG_GATE_TICKS, 16'd0),
            reg_row(REG_SETTLE_TICKS, 16'd0),
            tick_row(1'b1, 1'b1, 3'b110),   // every segment empty, no groups
            tick_row(1'b1, 1'b1, 3'b110),   // disarmed
            reg_row(REG_DEBOUNCE_TICKS, 16'd0),
            tick_row(1'b0, 1'b1, 3'b110),   // rearmed and done in one tick
            tick_row(1'b0, 1'b1, 3'b110),
            reg_row(REG_REPEAT_COUNT, 16'd1),
            reg_row(REG_BIT_TICKS, 16'd0),
            reg_row(REG_GAP_TICKS, 16'd0),
            reg_row(REG_REGION_MODE, {13'd0, REGION_UNUSED}),
            reg_row(REG_DEBOUNCE_TICKS, 16'd2),
            reg_row(REG_WAKE_TICKS, 16'd1),
            reg_row(REG_GATE_TICKS, 16'd1),
            reg_row(REG_SETTLE_TICKS, 16'd1),
            tick_row(1'b1, 1'b1, 3'b110),
            // bounce inside the debounce window, low again at its end
            tick_row(1'b0, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            tick_row(1'b0, 1'b0, 3'b000),
            tick_row(1'b0, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            tick_row(1'b0, 1'b0, 3'b000),
            tick_row(1'b0, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            tick_row(1'b0, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            reg_row(REG_REGION_MODE, {13'd0, REGION_I}),
            tick_row(1'b0, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000),
            tick_row(1'b1, 1'b0, 3'b000)
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (!cfg_open)
                    drain();
                cfg_open = 1'b1;
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                if (cfg_open)
                    cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_tick(plan[i].door, plan[i].pinned, plan[i].want);
            end
        end

        door_now = 1'b1;
        run_left = 0;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            style = (p == 1) ? ALL_MIN : (p == 4) ? ALL_MAX : MIX_SMALL;
            s = pick_settings(style);
            load_settings(s);
            gaps_on = (p != 3);
            if (p == 5)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (run_left == 0)
                begin
                    door_now = ~door_now;
                    if (door_now)
                        run_left = $urandom_range(1, 40);
                    else if ($urandom_range(0, 4) != 0)
                    begin
                        // real press: held past the debounce interval unless the cap on run_left cuts it short
                        press_len = int'(s.debounce_ticks) + 1 + $urandom_range(0, 3);
                        run_left = (press_len > 400) ? 400 : press_len;
                    end
                    else
                        run_left = $urandom_range(1, 3);
                end
                run_left = run_left - 1;
                send_tick(door_now, 1'b0, '0);
            end
        end
        gaps_on = 1'b1;

        drain();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
